// ----- hdl/crcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// crcfr_pkg: shared types and constants of the framed byte receiver
// Holds the queue entry layout, reset values and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package crcfr_pkg;

   // default payload capacity of one frame (command byte excluded)
   localparam int MAX_PAYLOAD_DEF = 32;

   localparam logic [7:0]  START_BYTE_RST = 8'h02;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [15:0] CRC_MSB        = 16'h8000;

   // one body byte as it travels through the frame queue
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       is_command;
      logic [5:0] payload_length;
      logic       last_in_frame;
   } crcfr_entry_type;

   // parser to queue: write, commit and abort of the frame in progress
   typedef struct packed {
      logic            wr_en;
      logic            commit;
      logic            abort;
      crcfr_entry_type entry;
   } crcfr_wr_type;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- hdl/crcfr_front.sv -----
// ----------------------------------------------------------------------------
// crcfr_front: frame parser
// Hunts for the start byte, checks the length, tags body bytes into the frame
// queue, keeps the running CRC and commits or aborts the frame at its end.
// ----------------------------------------------------------------------------
module crcfr_front #(
   parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_rx_byte,
   output logic                req_full,
   input  logic                csr_valid,
   input  logic [7:0]          csr_wdata,
   input  logic                space_ok,
   output crcfr_pkg::crcfr_wr_type wr
);
   import crcfr_pkg::*;

   localparam int STORE_DEPTH = MAX_PAYLOAD + 1;
   localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

   typedef enum logic [4:0] {
      PH_HUNT   = 5'b00001,
      PH_LEN    = 5'b00010,
      PH_BODY   = 5'b00100,
      PH_CRC_LO = 5'b01000,
      PH_CRC_HI = 5'b10000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       start_ff, start_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic             accept;
   logic             len_bad;
   logic             crc_match;

   // a new frame may only open when the queue has room for a whole body
   assign req_full = (phase_ff == PH_HUNT) && !space_ok;
   assign accept   = req_push && !req_full;

   assign len_bad   = (req_rx_byte == 8'h00) || (req_rx_byte > 8'(STORE_DEPTH));
   assign crc_match = ({req_rx_byte, crc_lo_ff} == crc_ff);

   // start byte register
   assign start_in = csr_valid ? csr_wdata : start_ff;

   // parse step
   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      wr        = '0;
      wr.entry.frame_byte     = req_rx_byte;
      wr.entry.is_command     = (idx_ff == '0);
      wr.entry.payload_length = 6'(len_ff - 1'b1);
      wr.entry.last_in_frame  = (LEN_W'(idx_ff + 1'b1) == len_ff);
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == start_ff) begin
                  crc_in   = CRC_INIT;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (len_bad) begin
                  phase_in = PH_HUNT;
               end else begin
                  len_in   = LEN_W'(req_rx_byte);
                  idx_in   = '0;
                  crc_in   = crc_feed(crc_ff, req_rx_byte);
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               wr.wr_en = 1'b1;
               crc_in   = crc_feed(crc_ff, req_rx_byte);
               idx_in   = LEN_W'(idx_ff + 1'b1);
               if (wr.entry.last_in_frame) begin
                  phase_in = PH_CRC_LO;
               end
            end
            PH_CRC_LO: begin
               crc_lo_in = req_rx_byte;
               phase_in  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               wr.commit = crc_match;
               wr.abort  = !crc_match;
               phase_in  = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         start_ff  <= START_BYTE_RST;
         len_ff    <= '0;
         idx_ff    <= '0;
         crc_ff    <= CRC_INIT;
         crc_lo_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

endmodule

// ----- hdl/crcfr_queue.sv -----
// ----------------------------------------------------------------------------
// crcfr_queue: frame queue between parser and output stage
// Ring memory of tagged body bytes. Bytes of the open frame sit between the
// commit and write pointers; an abort rolls the write pointer back.
// ----------------------------------------------------------------------------
module crcfr_queue #(
   parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  crcfr_pkg::crcfr_wr_type   wr,
   output logic                      space_ok,
   input  logic                      rd_en,
   output logic                      rd_avail,
   output crcfr_pkg::crcfr_entry_type rd_data
);
   import crcfr_pkg::*;

   localparam int STORE_DEPTH = MAX_PAYLOAD + 1;
   localparam int AW          = $clog2(2 * STORE_DEPTH);
   localparam int DEPTH       = 1 << AW;

   crcfr_entry_type mem [DEPTH];
   crcfr_entry_type rd_data_ff;
   logic [AW:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW:0]     cm_ptr_ff, cm_ptr_in;
   logic [AW:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     used_cm;
   logic [AW:0]     used_wr;

   assign used_cm  = cm_ptr_ff - rd_ptr_ff;
   assign used_wr  = wr_ptr_ff - rd_ptr_ff;
   assign space_ok = (used_cm <= (AW+1)'(DEPTH - STORE_DEPTH));
   assign rd_avail = (cm_ptr_ff != rd_ptr_ff);
   assign rd_data  = rd_data_ff;

   // pointer update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      cm_ptr_in = cm_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr.wr_en) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (wr.commit) begin
         cm_ptr_in = wr_ptr_ff;
      end
      if (wr.abort) begin
         wr_ptr_in = cm_ptr_ff;
      end
      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         cm_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         cm_ptr_ff <= cm_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr_ptr_ff[AW-1:0]] <= wr.entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff[AW-1:0]];
      end
   end

   // occupancy never exceeds the ring
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      used_wr <= (AW+1)'(DEPTH))
      else $error("frame queue overflow");

   // committed bytes never run ahead of written bytes
   a_commit_order: assert property (@(posedge clock) disable iff (reset)
      used_cm <= used_wr)
      else $error("commit pointer passed write pointer");

   // reads only come from committed frames
   a_read_committed: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> rd_avail)
      else $error("read of uncommitted entry");

   // an abort drops the whole open frame
   a_abort_rollback: assert property (@(posedge clock) disable iff (reset)
      wr.abort |=> (wr_ptr_ff == cm_ptr_ff))
      else $error("abort left bytes behind");

endmodule

// ----- hdl/crcfr_back.sv -----
// ----------------------------------------------------------------------------
// crcfr_back: result output stage
// Fetches committed entries from the frame queue and holds the oldest one on
// the result ports until it is popped.
// ----------------------------------------------------------------------------
module crcfr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_avail,
   output logic                       rd_en,
   input  crcfr_pkg::crcfr_entry_type rd_data,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [7:0]                 rsp_frame_byte,
   output logic                       rsp_is_command,
   output logic [5:0]                 rsp_payload_length,
   output logic                       rsp_last_in_frame
);
   import crcfr_pkg::*;

   logic            pend_ff, pend_in;
   logic            out_valid_ff, out_valid_in;
   crcfr_entry_type out_ff, out_in;
   logic            pop_fire;

   assign pop_fire = rsp_pop && out_valid_ff;
   // fetch only when the output register is free by the time data lands
   assign rd_en    = rd_avail && !pend_ff && (!out_valid_ff || pop_fire);
   assign pend_in  = rd_en;

   // output register load and release
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (pend_ff) begin
         out_valid_in = 1'b1;
         out_in       = rd_data;
      end else if (pop_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_frame_byte     = out_ff.frame_byte;
   assign rsp_is_command     = out_ff.is_command;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_last_in_frame  = out_ff.last_in_frame;

   // fetched data never lands on an item still waiting
   a_land_free: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !out_valid_ff)
      else $error("fetched item would overwrite waiting item");

endmodule

// ----- hdl/crc16_framed_byte_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// crc16_framed_byte_receiver_unit: framed byte receiver with CRC-16 check
// Parses start/length/body/CRC frames and emits good bodies byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue write port: a byte is taken at a clock edge with
//   req_push high and req_full low. The parser takes one byte per cycle
//   unless held off by req_full, which rises only while hunting for a start
//   byte and the frame queue lacks room for a full body (MAX_PAYLOAD+1 bytes).
//   Response side is a queue read port: the oldest body byte of a good frame
//   is shown while rsp_empty is low and taken when rsp_pop is high. The
//   command byte comes first (rsp_is_command), the last byte carries
//   rsp_last_in_frame. Frames with a bad length or CRC yield nothing.
//   After the edge that takes the CRC high byte, the first result passes the
//   registered read of the frame queue memory feeding one output register; the
//   output stage does not fetch a new entry while the last fetch is landing.
//   A stalled response side fills the queue (2**clog2(2*(MAX_PAYLOAD+1))
//   entries) and then holds off new frames through req_full.
//   csr_* writes the start byte (ready always high); write it while idle.
//   Synchronous reset empties the queue, sets the start byte to 2 and
//   returns the parser to hunting.
// ----------------------------------------------------------------------------
module crc16_framed_byte_receiver_unit #(
   parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_is_command,
   output logic [5:0] rsp_payload_length,
   output logic       rsp_last_in_frame,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_wdata
);
   import crcfr_pkg::*;

   crcfr_wr_type    wr;
   crcfr_entry_type rd_data;
   logic            space_ok;
   logic            rd_en;
   logic            rd_avail;

   assign csr_ready = 1'b1;

   // parser
   crcfr_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .csr_valid   (csr_valid),
      .csr_wdata   (csr_wdata),
      .space_ok    (space_ok),
      .wr          (wr)
   );

   // frame queue
   crcfr_queue #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .space_ok (space_ok),
      .rd_en    (rd_en),
      .rd_avail (rd_avail),
      .rd_data  (rd_data)
   );

   // output stage
   crcfr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .rd_avail           (rd_avail),
      .rd_en              (rd_en),
      .rd_data            (rd_data),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_is_command     (rsp_is_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last_in_frame  (rsp_last_in_frame)
   );

endmodule

// ----- tb/crc16_framed_byte_receiver_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_framed_byte_receiver_unit_test: self-checking bench for the receiver
// Feeds byte streams with good, corrupt, truncated and malformed frames under
// several start byte settings and random idling on both queue ports. A local
// frame parser predicts every body byte the block must return.
// ----------------------------------------------------------------------------
module crc16_framed_byte_receiver_unit_test;
   import crcfr_pkg::*;

   localparam int BODY_DEPTH    = MAX_PAYLOAD_DEF + 1;
   localparam int SETTLE_CYCLES = 10;
   localparam int REPORT_LIMIT  = 10;

   // parser phases of the local frame parser
   typedef enum logic [4:0] {
      SEEK_START = 5'b00001,
      GET_LENGTH = 5'b00010,
      GET_BODY   = 5'b00100,
      GET_CRC_LO = 5'b01000,
      GET_CRC_HI = 5'b10000
   } rx_phase_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   logic [7:0] req_rx_byte;
   logic       req_full;
   logic       rsp_pop;
   logic       rsp_empty;
   logic [7:0] rsp_frame_byte;
   logic       rsp_is_command;
   logic [5:0] rsp_payload_length;
   logic       rsp_last_in_frame;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_wdata;

   // local parser state and start byte copy
   rx_phase_type rx_phase;
   logic [5:0]   rx_len;
   logic [5:0]   rx_idx;
   logic [15:0]  rx_crc;
   logic [7:0]   rx_crc_lo;
   logic [7:0]   rx_body [BODY_DEPTH];
   logic [7:0]   cfg_start;

   // body bytes still owed by the block, oldest first
   crcfr_entry_type pending_bytes[$];
   // body of the next frame to transmit
   logic [7:0]      body_bytes[$];

   int send_gap_max = 4;
   int pop_gap_max  = 4;
   int fail_count   = 0;
   int bytes_sent   = 0;
   int results_seen = 0;
   int frames_good  = 0;
   int frames_lost  = 0;
   int cfg_writes   = 0;
   int full_stalls  = 0;

   crc16_framed_byte_receiver_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_rx_byte        (req_rx_byte),
      .req_full           (req_full),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_is_command     (rsp_is_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last_in_frame  (rsp_last_in_frame),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // CRC-16/CCITT-FALSE update, one bit at a time with the feedback bit
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // advance the local parser by one byte; queue the body on a good CRC
   function automatic void parse_byte(input logic [7:0] b);
      crcfr_entry_type e;
      logic [15:0]     got;
      case (rx_phase)
         SEEK_START: begin
            if (b == cfg_start) begin
               rx_crc   = CRC_INIT;
               rx_phase = GET_LENGTH;
            end
         end
         GET_LENGTH: begin
            if (b == 8'h00 || b > BODY_DEPTH) begin
               rx_phase = SEEK_START;
               frames_lost++;
            end else begin
               rx_len   = b[5:0];
               rx_idx   = 6'd0;
               rx_crc   = crc16_step(rx_crc, b);
               rx_phase = GET_BODY;
            end
         end
         GET_BODY: begin
            if (rx_idx < BODY_DEPTH) begin
               rx_body[rx_idx] = b;
            end
            rx_crc = crc16_step(rx_crc, b);
            rx_idx = rx_idx + 6'd1;
            if (rx_idx >= rx_len) begin
               rx_phase = GET_CRC_LO;
            end
         end
         GET_CRC_LO: begin
            rx_crc_lo = b;
            rx_phase  = GET_CRC_HI;
         end
         GET_CRC_HI: begin
            got      = {b, rx_crc_lo};
            rx_phase = SEEK_START;
            if (got == rx_crc) begin
               frames_good++;
               for (int i = 0; i < rx_len; i++) begin
                  e.frame_byte     = rx_body[i];
                  e.is_command     = (i == 0);
                  e.payload_length = 6'(rx_len - 6'd1);
                  e.last_in_frame  = (i == rx_len - 1);
                  pending_bytes.push_back(e);
               end
            end else begin
               frames_lost++;
            end
         end
         default: rx_phase = SEEK_START;
      endcase
   endfunction

   // push one byte after a random gap; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      bit taken;
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         if (!req_full) begin
            taken = 1'b1;
            bytes_sent++;
            parse_byte(b);
         end else begin
            full_stalls++;
         end
         @(negedge clock);
      end
   endtask

   // start, length, body_bytes, CRC low, CRC high; optionally corrupt CRC
   task automatic transmit_frame(input bit bad_crc);
      logic [15:0] crc;
      crc = crc16_step(CRC_INIT, 8'(body_bytes.size()));
      foreach (body_bytes[i]) crc = crc16_step(crc, body_bytes[i]);
      if (bad_crc) begin
         crc = crc ^ 16'($urandom_range(65535, 1));
      end
      send_byte(cfg_start);
      send_byte(8'(body_bytes.size()));
      foreach (body_bytes[i]) send_byte(body_bytes[i]);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
   endtask

   task automatic fill_body(input int n);
      body_bytes.delete();
      repeat (n) body_bytes.push_back(8'($urandom_range(255, 0)));
   endtask

   // stop sending and wait for every owed byte plus the output latency
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_start_byte(input logic [7:0] v);
      bit taken;
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         if (csr_ready) begin
            taken     = 1'b1;
            cfg_start = v;
            cfg_writes++;
         end
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // result side: random pop gaps, every popped item checked in order
   initial begin : drain_side
      int              gap;
      bit              taken;
      crcfr_entry_type want;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = $urandom_range(pop_gap_max, 0);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         taken = 1'b0;
         while (!taken) begin
            @(posedge clock);
            if (!rsp_empty) begin
               taken = 1'b1;
               results_seen++;
               if (pending_bytes.size() == 0) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("unexpected item: byte %02h cmd %0b plen %0d last %0b",
                              rsp_frame_byte, rsp_is_command, rsp_payload_length,
                              rsp_last_in_frame);
                  end
               end else begin
                  want = pending_bytes.pop_front();
                  if (want.frame_byte !== rsp_frame_byte ||
                      want.is_command !== rsp_is_command ||
                      want.payload_length !== rsp_payload_length ||
                      want.last_in_frame !== rsp_last_in_frame) begin
                     fail_count++;
                     if (fail_count <= REPORT_LIMIT) begin
                        $display("item %0d: want byte %02h cmd %0b plen %0d last %0b",
                                 results_seen, want.frame_byte, want.is_command,
                                 want.payload_length, want.last_in_frame);
                        $display("         got  byte %02h cmd %0b plen %0d last %0b",
                                 rsp_frame_byte, rsp_is_command, rsp_payload_length,
                                 rsp_last_in_frame);
                     end
                  end
               end
            end
            @(negedge clock);
         end
      end
   end

   // extremes and malformed frames under the reset start byte
   task automatic test_directed_frames();
      send_byte(8'h55);                      // noise while hunting
      body_bytes = '{8'h00};                 // command only, zero payload
      transmit_frame(1'b0);
      body_bytes = '{8'hFF, 8'h02, 8'h00};   // start byte value inside the body
      transmit_frame(1'b0);
      send_byte(cfg_start);                  // zero length
      send_byte(8'h00);
      send_byte(cfg_start);                  // one past the store
      send_byte(8'(BODY_DEPTH + 1));
      send_byte(cfg_start);                  // largest length byte
      send_byte(8'hFF);
      body_bytes = '{8'hA5};                 // CRC mismatch
      transmit_frame(1'b1);
   endtask

   // start byte at both ends of its range
   task automatic test_start_byte_extremes();
      logic [7:0] picks [2];
      picks = '{8'h00, 8'hFF};
      foreach (picks[p]) begin
         set_start_byte(picks[p]);
         repeat (2) begin
            fill_body($urandom_range(4, 1));
            transmit_frame(1'b0);
         end
      end
   endtask

   // sender holds off until everything owed has come back
   task automatic test_drain_pause();
      repeat (3) begin
         wait_idle();
         fill_body($urandom_range(8, 1));
         transmit_frame(1'b0);
      end
   endtask

   // mostly good frames, plus corrupt, malformed, noisy and cut-off ones
   task automatic test_random_traffic();
      int phase_end;
      int frames;
      int kind;
      int n;
      for (int p = 0; p < 4; p++) begin
         set_start_byte(8'($urandom_range(255, 0)));
         send_gap_max = (p == 1 || p == 3) ? 4 : 0;
         pop_gap_max  = (p == 1 || p == 2) ? 4 : 0;
         phase_end = bytes_sent + 60;
         frames = 0;
         while (bytes_sent < phase_end) begin
            frames++;
            if (frames % 6 == 0) begin
               wait_idle();
            end
            kind = $urandom_range(99, 0);
            n    = $urandom_range(99, 0);
            n    = (n < 8) ? BODY_DEPTH : (n < 30) ? $urandom_range(32, 9) : $urandom_range(8, 1);
            if (kind < 70) begin
               fill_body(n);
               transmit_frame(1'b0);
            end else if (kind < 80) begin
               fill_body(n);
               transmit_frame(1'b1);
            end else if (kind < 86) begin
               send_byte(cfg_start);
               send_byte(kind < 83 ? 8'h00 : 8'($urandom_range(255, BODY_DEPTH + 1)));
            end else if (kind < 94) begin
               repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255, 0)));
            end else begin
               // frame cut short; the parser swallows whatever follows
               send_byte(cfg_start);
               send_byte(8'(n));
               repeat ($urandom_range(n - 1, 0)) send_byte(8'($urandom_range(255, 0)));
            end
         end
      end
      send_gap_max = 4;
      pop_gap_max  = 4;
   endtask

   // full-size frames back to back against a slow consumer to fill the queue
   task automatic test_backpressure();
      send_gap_max = 0;
      pop_gap_max  = 4;
      repeat (5) begin
         fill_body(BODY_DEPTH);
         transmit_frame(1'b0);
      end
      send_gap_max = 4;
   endtask

   initial begin
      reset       <= 1'b1;
      req_push    <= 1'b0;
      req_rx_byte <= 8'h00;
      rsp_pop     <= 1'b0;
      csr_valid   <= 1'b0;
      csr_wdata   <= 8'h00;
      rx_phase  = SEEK_START;
      rx_len    = 6'd0;
      rx_idx    = 6'd0;
      rx_crc    = CRC_INIT;
      rx_crc_lo = 8'h00;
      cfg_start = START_BYTE_RST;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_start_byte_extremes();
      test_drain_pause();
      test_random_traffic();
      test_backpressure();
      wait_idle();

      $display("sent %0d bytes: %0d good frames, %0d dropped, %0d items checked",
               bytes_sent, frames_good, frames_lost, results_seen);
      $display("start byte writes %0d, cycles held off by full %0d, failures %0d",
               cfg_writes, full_stalls, fail_count);
      if (fail_count == 0 && pending_bytes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
